// ===== design/rrts_pkg.sv =====
// Shared types and constants for the round-robin thread scheduler.
// No dependencies; every other design file imports this package.
package rrts_pkg;

	localparam int SLOTS      = 8;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int TID_W      = 16;
	localparam int SLOT_OUT_W = 3;

	// slot states
	localparam logic [1:0] ST_FREE     = 2'd0;
	localparam logic [1:0] ST_RUNNABLE = 2'd1;
	localparam logic [1:0] ST_RUNNING  = 2'd2;
	localparam logic [1:0] ST_ZOMBIE   = 2'd3;

	// request kinds
	localparam logic [1:0] FN_CREATE = 2'd0;
	localparam logic [1:0] FN_YIELD  = 2'd1;
	localparam logic [1:0] FN_EXIT   = 2'd2;
	localparam logic [1:0] FN_JOIN   = 2'd3;

	// result status codes
	localparam logic [1:0] RS_DONE     = 2'd0;
	localparam logic [1:0] RS_FULL     = 2'd1;
	localparam logic [1:0] RS_NOTFOUND = 2'd2;
	localparam logic [1:0] RS_WAITING  = 2'd3;

	typedef struct packed {
		logic take;    // latch the incoming request word
		logic commit;  // update the slot table and load the result register
	} cmd_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [TID_W-1:0]      new_tid;
		logic                  switched;
		logic [SLOT_OUT_W-1:0] from_slot;
		logic [SLOT_OUT_W-1:0] to_slot;
	} rsp_t;

endpackage

// ===== design/round_robin_thread_scheduler_top.sv =====
// Top level of the round-robin thread scheduler: stream ports, controller
// and datapath. Depends on rrts_pkg, rrts_ctrl and rrts_dp.
//
//   channel   direction  handshake             payload
//   s_*       in         s_tvalid / s_tready   tuser: func; tdata: target_tid
//   m_*       out        m_tvalid / m_tready   tuser: status; tdata: result fields
//
// A request is latched in the accept cycle; the execute state then runs the
// free-slot, id-match and round-robin scans over the eight-slot table and
// commits. s_tready is low while in the execute state.
// Reset puts slot 0 running, all others free, id counter at 1; no sweep.
// While an unread result sits in the output register a new request is still
// accepted, but its execute cycle holds until m_tready frees the register.
module round_robin_thread_scheduler_top import rrts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // [1:0] func
	input  logic [15:0] s_tdata,   // [15:0] target_tid
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic [23:0] m_tdata    // [15:0] new_tid, [16] switched,
	                               // [19:17] from_slot, [22:20] to_slot, [23] zero
);

	cmd_t cmd;
	rsp_t rsp;

	rrts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	rrts_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.func       (s_tuser),
		.target_tid (s_tdata[TID_W-1:0]),
		.rsp        (rsp)
	);

	assign m_tuser = rsp.status;
	assign m_tdata = {1'b0, rsp.to_slot, rsp.from_slot, rsp.switched, rsp.new_tid};

	// one request in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another was executing");

	// no switch means the running slot did not move
	a_no_switch_same_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[16]) |-> (m_tdata[19:17] == m_tdata[22:20]))
		else $error("slot changed without a switch");

	// failed requests neither switch nor hand out an id
	a_fail_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == RS_FULL || m_tuser == RS_NOTFOUND))
		|-> (!m_tdata[16] && m_tdata[15:0] == 16'd0))
		else $error("failed request switched or returned an id");

	// only a create returns an id, so a waiting join carries none
	a_wait_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == RS_WAITING) |-> (m_tdata[15:0] == 16'd0))
		else $error("waiting join returned an id");

endmodule

// ===== design/rrts_ctrl.sv =====
// Controller of the round-robin thread scheduler: request sequencing and
// result register occupancy. Depends on rrts_pkg.
module rrts_ctrl import rrts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic commit;

	assign in_ready   = (state_q == S_IDLE);
	assign commit     = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign cmd.take   = in_ready && in_valid;
	assign cmd.commit = commit;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					// hold until the result register is free
					if (commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/rrts_dp.sv =====
// Datapath of the round-robin thread scheduler: slot table, running slot,
// id counter, request latch and result register. Depends on rrts_pkg.
module rrts_dp import rrts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [1:0]       func,
	input  logic [TID_W-1:0] target_tid,
	output rsp_t             rsp
);

	logic [SLOTS-1:0][1:0]       slot_state_q;
	logic [SLOTS-1:0][TID_W-1:0] slot_tid_q;
	logic [SLOT_W-1:0]           run_q;
	logic [TID_W-1:0]            tid_cnt_q;
	logic [1:0]                  func_q;
	logic [TID_W-1:0]            target_q;
	rsp_t                        rsp_q;

	logic [SLOTS-1:0][1:0]       st_n;
	logic [SLOTS-1:0][TID_W-1:0] tid_n;
	logic [SLOT_W-1:0]           run_n;
	logic [TID_W-1:0]            cnt_n;
	rsp_t                        rsp_n;

	always_comb begin
		logic              found;
		logic [SLOT_W-1:0] pick;
		logic              do_yield;
		logic              y_found;
		logic [SLOT_W-1:0] y_idx;
		logic [SLOT_W:0]   sum;

		st_n     = slot_state_q;
		tid_n    = slot_tid_q;
		run_n    = run_q;
		cnt_n    = tid_cnt_q;
		found    = 1'b0;
		pick     = '0;
		do_yield = 1'b0;
		y_found  = 1'b0;
		y_idx    = '0;
		sum      = '0;
		rsp_n.status  = RS_DONE;
		rsp_n.new_tid = '0;

		case (func_q)
			FN_CREATE: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && slot_state_q[i] == ST_FREE) begin
						found = 1'b1;
						pick  = SLOT_W'(i);
					end
				end
				if (!found) begin
					rsp_n.status = RS_FULL;
				end else begin
					st_n[pick]    = ST_RUNNABLE;
					tid_n[pick]   = tid_cnt_q;
					rsp_n.new_tid = tid_cnt_q;
					cnt_n         = tid_cnt_q + 1'b1;
				end
			end
			FN_YIELD: begin
				do_yield = 1'b1;
			end
			FN_EXIT: begin
				st_n[run_q] = ST_ZOMBIE;
				do_yield    = 1'b1;
			end
			FN_JOIN: begin
				// lowest live slot whose id matches
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && slot_state_q[i] != ST_FREE && slot_tid_q[i] == target_q) begin
						found = 1'b1;
						pick  = SLOT_W'(i);
					end
				end
				if (!found) begin
					rsp_n.status = RS_NOTFOUND;
				end else if (slot_state_q[pick] == ST_ZOMBIE) begin
					st_n[pick] = ST_FREE;
				end else begin
					rsp_n.status = RS_WAITING;
					do_yield     = 1'b1;
				end
			end
			default: begin
				do_yield = 1'b0;
			end
		endcase

		// round-robin scan starting just after the current slot, ending on it
		if (do_yield) begin
			for (int i = 1; i <= SLOTS; i++) begin
				sum = {1'b0, run_q} + (SLOT_W+1)'(i);
				if (sum >= (SLOT_W+1)'(SLOTS)) sum = sum - (SLOT_W+1)'(SLOTS);
				if (!y_found && st_n[sum[SLOT_W-1:0]] == ST_RUNNABLE) begin
					y_found = 1'b1;
					y_idx   = sum[SLOT_W-1:0];
				end
			end
		end
		if (y_found) begin
			if (y_idx != run_q && st_n[run_q] == ST_RUNNING) st_n[run_q] = ST_RUNNABLE;
			st_n[y_idx] = ST_RUNNING;
			run_n       = y_idx;
		end

		rsp_n.switched  = y_found && (y_idx != run_q);
		rsp_n.from_slot = SLOT_OUT_W'(run_q);
		rsp_n.to_slot   = SLOT_OUT_W'(run_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_state_q[i] <= ST_FREE;
				slot_tid_q[i]   <= '0;
			end
			slot_state_q[0] <= ST_RUNNING;
			run_q           <= '0;
			tid_cnt_q       <= TID_W'(1);
		end else if (cmd.commit) begin
			slot_state_q <= st_n;
			slot_tid_q   <= tid_n;
			run_q        <= run_n;
			tid_cnt_q    <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q   <= func;
			target_q <= target_tid;
		end
		if (cmd.commit) rsp_q <= rsp_n;
	end

	assign rsp = rsp_q;

endmodule
